FILE: src/hthq_pkg.sv
// hthq_pkg: shared constants, codes and types of the heightmap height query block
// no dependencies; imported by the store, the top level, the checker and the testbench
`default_nettype none

package hthq_pkg;

  localparam int unsigned GRID_WIDTH = 256;
  localparam int unsigned GRID_DEPTH = 256;
  localparam int unsigned COL_W      = $clog2(GRID_WIDTH);
  localparam int unsigned ROW_W      = $clog2(GRID_DEPTH);
  localparam int unsigned BANK_AW    = COL_W + ROW_W - 2;
  localparam int unsigned BANK_DEPTH = 2 ** BANK_AW;
  localparam int unsigned APB_AW     = 4;
  localparam int unsigned LATENCY    = 7;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OFFSET_X    = 2'd0,
    REG_OFFSET_Z    = 2'd1,
    REG_INV_SCALE   = 2'd2,
    REG_HEIGHT_GAIN = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } rd_req_t;

  typedef struct packed {
    logic [7:0] d00;
    logic [7:0] d10;
    logic [7:0] d01;
    logic [7:0] d11;
  } corners_t;

endpackage

`default_nettype wire

FILE: src/hthq_store.sv
// hthq_store: height sample store, four banks split by row and column parity
// one read of all four cell corners per cycle, one write; uses hthq_pkg
`default_nettype none

module hthq_store (
  input  logic               clk_i,
  input  hthq_pkg::wr_req_t  wr_i,
  input  hthq_pkg::rd_req_t  rd_i,
  output hthq_pkg::corners_t corners_o
);
  import hthq_pkg::*;

  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic [BANK_AW-1:0] waddr;
  logic [7:0]         rd_data [4];
  logic [1:0]         par_q;

  assign col_next = rd_i.col + COL_W'(1);
  assign row_next = rd_i.row + ROW_W'(1);
  assign waddr    = {wr_i.row[ROW_W-1:1], wr_i.col[COL_W-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CB = 1'(b % 2);
    localparam logic RB = 1'(b / 2);

    logic [7:0]         mem [BANK_DEPTH];
    logic [7:0]         rdata_q;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [BANK_AW-1:0] raddr;

    assign col   = (rd_i.col[0] == CB) ? rd_i.col : col_next;
    assign row   = (rd_i.row[0] == RB) ? rd_i.row : row_next;
    assign raddr = {row[ROW_W-1:1], col[COL_W-1:1]};

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.col[0] == CB) && (wr_i.row[0] == RB)) begin
        mem[waddr] <= wr_i.data;
      end
      rdata_q <= mem[raddr];
    end

    assign rd_data[b] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    par_q <= {rd_i.row[0], rd_i.col[0]};
  end

  // bank index is {row parity, column parity}
  assign corners_o.d00 = rd_data[{par_q[1], par_q[0]}];
  assign corners_o.d10 = rd_data[{par_q[1], ~par_q[0]}];
  assign corners_o.d01 = rd_data[{~par_q[1], par_q[0]}];
  assign corners_o.d11 = rd_data[{~par_q[1], ~par_q[0]}];

endmodule

`default_nettype wire

FILE: src/heightmap_triangle_height_query.sv
// heightmap_triangle_height_query: top level, config registers and query pipeline
// uses hthq_pkg and hthq_store
// throughput: one word per cycle, writes and queries mixed; busy_o stays low
// the four-bank sample store delivers all corners of a cell in one read
// reset clears the pipeline valid bits and loads register defaults; samples are kept
`default_nettype none

module heightmap_triangle_height_query (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hthq_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        command_i,
  input  logic [7:0]                  cell_x_i,
  input  logic [7:0]                  cell_z_i,
  input  logic [7:0]                  height_byte_i,
  input  logic [31:0]                 pos_x_i,
  input  logic [31:0]                 pos_z_i,
  output logic                        result_valid_o,
  output logic [31:0]                 height_o,
  output logic                        in_range_o
);
  import hthq_pkg::*;

  function automatic logic signed [9:0] sample_val(input logic [7:0] b);
    return $signed({2'b00, b}) - 10'sd128;
  endfunction

  // configuration
  logic [31:0] offset_x_q, offset_z_q;
  logic [23:0] inv_scale_q;
  logic [15:0] height_gain_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_z_q    <= '0;
      inv_scale_q   <= 24'h010000;
      height_gain_q <= 16'd384;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OFFSET_X:    offset_x_q    <= pwdata;
        REG_OFFSET_Z:    offset_z_q    <= pwdata;
        REG_INV_SCALE:   inv_scale_q   <= pwdata[23:0];
        REG_HEIGHT_GAIN: height_gain_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_X:    prdata = offset_x_q;
      REG_OFFSET_Z:    prdata = offset_z_q;
      REG_INV_SCALE:   prdata = {8'h00, inv_scale_q};
      REG_HEIGHT_GAIN: prdata = {16'h0000, height_gain_q};
      default:         prdata = '0;
    endcase
  end

  assign busy_o = 1'b0;

  // stage 1: offset add
  logic                    accept;
  logic                    s1_vld_q;
  cmd_e                    s1_cmd_q;
  logic                    s1_wok_q;
  logic [COL_W-1:0]        s1_col_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic [7:0]              s1_data_q;
  logic signed [32:0]      s1_sx_q, s1_sz_q;
  logic                    wr_ok;

  assign accept = start_i && !busy_o;
  assign wr_ok  = (32'(cell_x_i) < GRID_WIDTH) && (32'(cell_z_i) < GRID_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= cmd_e'(command_i);
    s1_wok_q  <= wr_ok;
    s1_col_q  <= COL_W'(cell_x_i);
    s1_row_q  <= ROW_W'(cell_z_i);
    s1_data_q <= height_byte_i;
    s1_sx_q   <= $signed({pos_x_i[31], pos_x_i}) + $signed({offset_x_q[31], offset_x_q});
    s1_sz_q   <= $signed({pos_z_i[31], pos_z_i}) + $signed({offset_z_q[31], offset_z_q});
  end

  // stage 2: scale by inverse cell size
  logic               s2_vld_q;
  cmd_e               s2_cmd_q;
  logic               s2_wok_q;
  logic [COL_W-1:0]   s2_col_q;
  logic [ROW_W-1:0]   s2_row_q;
  logic [7:0]         s2_data_q;
  logic signed [57:0] s2_px_q, s2_pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q  <= s1_cmd_q;
    s2_wok_q  <= s1_wok_q;
    s2_col_q  <= s1_col_q;
    s2_row_q  <= s1_row_q;
    s2_data_q <= s1_data_q;
    s2_px_q   <= s1_sx_q * $signed({1'b0, inv_scale_q});
    s2_pz_q   <= s1_sz_q * $signed({1'b0, inv_scale_q});
  end

  // stage 3: cell split, range check, sample read or write
  logic [15:0] fx, fz;
  logic        x_ok, z_ok, upper;
  wr_req_t     wr_req;
  rd_req_t     rd_req;
  corners_t    corners;

  assign fx    = s2_px_q[31:16];
  assign fz    = s2_pz_q[31:16];
  assign x_ok  = !s2_px_q[57] && (s2_px_q[56:32] <= 25'(GRID_WIDTH - 2));
  assign z_ok  = !s2_pz_q[57] && (s2_pz_q[56:32] <= 25'(GRID_DEPTH - 2));
  assign upper = ({1'b0, fx} + {1'b0, fz}) > 17'h10000;

  assign rd_req.col  = s2_px_q[32 +: COL_W];
  assign rd_req.row  = s2_pz_q[32 +: ROW_W];
  assign wr_req.en   = s2_vld_q && (s2_cmd_q == CMD_WRITE) && s2_wok_q;
  assign wr_req.col  = s2_col_q;
  assign wr_req.row  = s2_row_q;
  assign wr_req.data = s2_data_q;

  hthq_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_i      (rd_req),
    .corners_o (corners)
  );

  logic        s3_vld_q, s3_inr_q, s3_upper_q;
  logic [15:0] s3_fx_q, s3_fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q && (s2_cmd_q == CMD_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_inr_q   <= x_ok && z_ok;
    s3_upper_q <= upper;
    s3_fx_q    <= fx;
    s3_fz_q    <= fz;
  end

  // stage 4: triangle weights times corner deltas
  logic signed [9:0]  d00, d10, d01, d11, base, da, db;
  logic [15:0]        wa, wb;
  logic               s4_vld_q, s4_inr_q;
  logic signed [9:0]  s4_base_q;
  logic signed [26:0] s4_pa_q, s4_pb_q;

  assign d00 = sample_val(corners.d00);
  assign d10 = sample_val(corners.d10);
  assign d01 = sample_val(corners.d01);
  assign d11 = sample_val(corners.d11);

  // upper triangle is taken around the far corner
  assign base = s3_upper_q ? d11 : d00;
  assign da   = s3_upper_q ? (d10 - d11) : (d10 - d00);
  assign db   = s3_upper_q ? (d01 - d11) : (d01 - d00);
  assign wa   = s3_upper_q ? 16'(17'h10000 - {1'b0, s3_fz_q}) : s3_fx_q;
  assign wb   = s3_upper_q ? 16'(17'h10000 - {1'b0, s3_fx_q}) : s3_fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_inr_q  <= s3_inr_q;
    s4_base_q <= base;
    s4_pa_q   <= $signed({1'b0, wa}) * da;
    s4_pb_q   <= $signed({1'b0, wb}) * db;
  end

  // stage 5: accumulate
  logic               s5_vld_q, s5_inr_q;
  logic signed [27:0] s5_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_inr_q <= s4_inr_q;
    s5_acc_q <= $signed({s4_base_q, 16'h0000}) + s4_pa_q + s4_pb_q;
  end

  // stage 6: height gain
  logic               s6_vld_q, s6_inr_q;
  logic signed [44:0] s6_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_inr_q  <= s5_inr_q;
    s6_prod_q <= s5_acc_q * $signed({1'b0, height_gain_q});
  end

  // output word; scaled height stays within 26 bits, so no clipping is reached
  logic        out_vld_q, in_range_q;
  logic [31:0] height_q, height_d;

  assign height_d = s6_inr_q ? {s6_prod_q[44], s6_prod_q[44:14]} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      out_vld_q  <= s6_vld_q;
      in_range_q <= s6_vld_q && s6_inr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= height_d;
  end

  assign result_valid_o = out_vld_q;
  assign in_range_o     = in_range_q;
  assign height_o       = height_q;

endmodule

`default_nettype wire

FILE: src/hthq_checker.sv
// hthq_checker: port-level checks of the height query block
// uses hthq_pkg; bound to heightmap_triangle_height_query below
`default_nettype none

module hthq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        command_i,
  input logic        result_valid_o,
  input logic [31:0] height_o,
  input logic        in_range_o
);
  import hthq_pkg::*;

  logic query_acc;

  assign query_acc = start_i && !busy_o && (command_i == CMD_QUERY);

  a_query_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |-> ##LATENCY result_valid_o)
    else $error("query word did not return a result");

  a_word_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(query_acc, LATENCY))
    else $error("result word without a matching query");

  a_out_of_grid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !in_range_o) |-> (height_o == 32'h0))
    else $error("out of grid result with nonzero height");

  a_in_range_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_range_o |-> result_valid_o)
    else $error("in_range set without result strobe");

endmodule

bind heightmap_triangle_height_query hthq_checker u_hthq_checker (.*);

`default_nettype wire

FILE: tb/tb_heightmap_triangle_height_query.sv
// tb_heightmap_triangle_height_query: self-checking testbench of the heightmap height query block
// drives write and query words and config over apb, predicts every height in a local model
// depends on hthq_pkg and heightmap_triangle_height_query
`timescale 1ns / 100ps

module tb_heightmap_triangle_height_query;
  import hthq_pkg::*;

  typedef struct packed {
    logic [31:0] height;
    logic        in_range;
  } height_rec_t;

  localparam longint LAST_X    = GRID_WIDTH - 2;
  localparam longint LAST_Z    = GRID_DEPTH - 2;
  localparam int     DRAIN_CAP = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start_i;
  logic              busy_o;
  logic              command_i;
  logic [7:0]        cell_x_i;
  logic [7:0]        cell_z_i;
  logic [7:0]        height_byte_i;
  logic [31:0]       pos_x_i;
  logic [31:0]       pos_z_i;
  logic              result_valid_o;
  logic [31:0]       height_o;
  logic              in_range_o;

  heightmap_triangle_height_query i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .cell_x_i       (cell_x_i),
    .cell_z_i       (cell_z_i),
    .height_byte_i  (height_byte_i),
    .pos_x_i        (pos_x_i),
    .pos_z_i        (pos_z_i),
    .result_valid_o (result_valid_o),
    .height_o       (height_o),
    .in_range_o     (in_range_o)
  );

  logic [7:0]  sample_mem [0:GRID_WIDTH*GRID_DEPTH-1];
  bit          sample_set [0:GRID_WIDTH*GRID_DEPTH-1];
  logic [31:0] cfg_off_x;
  logic [31:0] cfg_off_z;
  logic [23:0] cfg_scale;
  logic [15:0] cfg_gain;
  height_rec_t pending_heights [$];
  int          fail_count;
  int          idle_pct;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  // scaled position in signed q25.16
  function automatic longint scaled_coord(logic [31:0] pos, logic [31:0] off);
    longint s;
    longint sc;
    s = longint'($signed(pos)) + longint'($signed(off));
    sc = longint'(cfg_scale);
    return (s * sc) >>> 16;
  endfunction

  function automatic longint corner(longint col, longint row);
    return longint'(sample_mem[row * GRID_WIDTH + col]) - 128;
  endfunction

  function automatic height_rec_t predict_height(logic [31:0] px, logic [31:0] pz);
    longint tx, tz, gx, gz, fx, fz, acc, h;
    longint d00, d10, d01, d11;
    height_rec_t rec;
    tx = scaled_coord(px, cfg_off_x);
    tz = scaled_coord(pz, cfg_off_z);
    gx = tx >>> 16;
    gz = tz >>> 16;
    fx = tx - gx * 65536;
    fz = tz - gz * 65536;
    if (gx < 0 || gz < 0 || gx > LAST_X || gz > LAST_Z) begin
      rec.height = '0;
      rec.in_range = 1'b0;
      return rec;
    end
    d00 = corner(gx, gz);
    d10 = corner(gx + 1, gz);
    d01 = corner(gx, gz + 1);
    d11 = corner(gx + 1, gz + 1);
    if (fx + fz <= 65536) begin
      acc = 65536 * d00 + fx * (d10 - d00) + fz * (d01 - d00);
    end else begin
      acc = (65536 - fz) * d10 + (fx + fz - 65536) * d11 + (65536 - fx) * d01;
    end
    h = (acc * longint'(cfg_gain)) >>> 14;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    rec.height = h[31:0];
    rec.in_range = 1'b1;
    return rec;
  endfunction

  // world position that lands on scaled position t, clipped to 32 bits
  function automatic logic [31:0] pos_for(longint t, logic [31:0] off);
    longint sc, s, p;
    sc = longint'(cfg_scale);
    if (sc == 0) return $urandom;
    if (t >= 0) s = (t * 65536 + sc - 1) / sc;
    else s = (t * 65536) / sc;
    p = s - longint'($signed(off));
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic longint pick_frac();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    return longint'($urandom_range(65535));
  endfunction

  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_check(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] back;
    case (idx)
      REG_INV_SCALE: mask = 32'h00FF_FFFF;
      REG_HEIGHT_GAIN: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    apb_xfer(1'b0, idx, 32'd0, back);
    if ((back & mask) !== (value & mask))
      note_failure($sformatf("reg %0d exp %h got %h", idx, value & mask, back & mask));
  endtask

  task automatic program_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] unused;
    case (idx)
      REG_OFFSET_X: cfg_off_x = value;
      REG_OFFSET_Z: cfg_off_z = value;
      REG_INV_SCALE: cfg_scale = value[23:0];
      default: cfg_gain = value[15:0];
    endcase
    apb_xfer(1'b1, idx, value, unused);
    read_check(idx, value);
  endtask

  task automatic program_all(input logic [31:0] ox, input logic [31:0] oz,
                             input logic [31:0] sc, input logic [31:0] g);
    program_reg(REG_OFFSET_X, ox);
    program_reg(REG_OFFSET_Z, oz);
    program_reg(REG_INV_SCALE, sc);
    program_reg(REG_HEIGHT_GAIN, g);
  endtask

  // one word into the block; returns in the time step of the accepting edge
  task automatic send_word(input cmd_e cmd, input logic [7:0] cx, input logic [7:0] cz,
                           input logic [7:0] hb, input logic [31:0] px, input logic [31:0] pz);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    cell_x_i <= cx;
    cell_z_i <= cz;
    height_byte_i <= hb;
    pos_x_i <= px;
    pos_z_i <= pz;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (busy_o === 1'b0);
      @(posedge clk_i);
    end
    if (cmd == CMD_WRITE) begin
      sample_mem[int'(cz) * GRID_WIDTH + int'(cx)] = hb;
      sample_set[int'(cz) * GRID_WIDTH + int'(cx)] = 1'b1;
    end else begin
      pending_heights = {pending_heights, predict_height(px, pz)};
    end
  endtask

  // loads any unwritten corner of the target cell first
  task automatic query_at(input logic [31:0] px, input logic [31:0] pz);
    longint gx, gz;
    logic [7:0] wx, wz;
    gx = scaled_coord(px, cfg_off_x) >>> 16;
    gz = scaled_coord(pz, cfg_off_z) >>> 16;
    if (gx >= 0 && gz >= 0 && gx <= LAST_X && gz <= LAST_Z) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!sample_set[(gz + dz) * GRID_WIDTH + gx + dx]) begin
            wx = 8'(gx + dx);
            wz = 8'(gz + dz);
            send_word(CMD_WRITE, wx, wz, 8'($urandom_range(255)), $urandom, $urandom);
          end
        end
      end
    end
    send_word(CMD_QUERY, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), px, pz);
  endtask

  task automatic query_cell(input longint gx, input longint gz, input longint fx,
                            input longint fz);
    query_at(pos_for(gx * 65536 + fx, cfg_off_x), pos_for(gz * 65536 + fz, cfg_off_z));
  endtask

  task automatic pick_cell(output longint gx, output longint gz);
    int r;
    r = $urandom_range(9);
    if (r < 5) begin
      gx = longint'($urandom_range(7));
      gz = longint'($urandom_range(7));
    end else if (r < 7) begin
      gx = longint'($urandom_range(32'(LAST_X), 32'(LAST_X - 7)));
      gz = longint'($urandom_range(32'(LAST_Z), 32'(LAST_Z - 7)));
    end else begin
      gx = longint'($urandom_range(32'(LAST_X)));
      gz = longint'($urandom_range(32'(LAST_Z)));
    end
  endtask

  task automatic drain_results();
    int waited;
    start_i <= 1'b0;
    waited = 0;
    while (pending_heights.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_heights.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_heights.size()));
      pending_heights.delete();
    end
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : result_check
    height_rec_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (result_valid_o !== 1'b1) begin
        note_failure("result strobe unknown");
      end else if (pending_heights.size() == 0) begin
        note_failure($sformatf("unexpected result height %h in_range %b", height_o, in_range_o));
      end else begin
        want = pending_heights.pop_front();
        if (height_o !== want.height)
          note_failure($sformatf("height exp %h got %h", want.height, height_o));
        if (in_range_o !== want.in_range)
          note_failure($sformatf("in_range exp %b got %b", want.in_range, in_range_o));
      end
    end
  end

  task automatic test_reset_values();
    read_check(REG_OFFSET_X, 32'd0);
    read_check(REG_OFFSET_Z, 32'd0);
    read_check(REG_INV_SCALE, 32'd65536);
    read_check(REG_HEIGHT_GAIN, 32'd384);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    // sample extremes around both grid corners
    send_word(CMD_WRITE, 8'd0, 8'd0, 8'd0, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd1, 8'd0, 8'd255, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd0, 8'd1, 8'd128, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd1, 8'd1, 8'd127, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd254, 8'd254, 8'd255, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd255, 8'd254, 8'd0, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd254, 8'd255, 8'd1, $urandom, $urandom);
    send_word(CMD_WRITE, 8'd255, 8'd255, 8'd254, $urandom, $urandom);
    query_at(32'h0000_0000, 32'h0000_0000);
    query_at(32'h0000_FFFF, 32'h0000_0000);
    query_at(32'h0000_0000, 32'h0000_FFFF);
    // triangle split on the diagonal, then the last grid cell
    query_at(32'h0000_8000, 32'h0000_8000);
    query_at(32'h0000_8001, 32'h0000_8000);
    query_at(32'h0000_FFFF, 32'h0000_FFFF);
    query_at(32'h00FE_0000, 32'h00FE_0000);
    query_at(32'h00FE_FFFF, 32'h00FE_FFFF);
    // out of grid
    query_at(32'h00FF_0000, 32'h0000_0000);
    query_at(32'h0000_0000, 32'h00FF_0000);
    query_at(32'hFFFF_FFFF, 32'h0000_0000);
    query_at(32'h7FFF_FFFF, 32'h8000_0000);
    query_at(32'h8000_0000, 32'h7FFF_FFFF);
    // query right behind a write to one of its corners
    send_word(CMD_WRITE, 8'd1, 8'd1, 8'd0, $urandom, $urandom);
    query_at(32'h0000_FFFF, 32'h0000_FFFF);
    send_word(CMD_WRITE, 8'd0, 8'd0, 8'd255, $urandom, $urandom);
    query_at(32'h0000_0000, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_config_extremes();
    logic [31:0] ox, oz, sc, g;
    longint gx, gz;
    idle_pct = 14;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin
          ox = 32'h8000_0000; oz = 32'h7FFF_FFFF; sc = 32'h0001_0000; g = 32'h0000_FFFF;
        end
        1: begin
          ox = 32'h7FFF_FFFF; oz = 32'h8000_0000; sc = 32'h00FF_FFFF; g = 32'h0000_0000;
        end
        2: begin
          ox = 32'h0000_0000; oz = 32'h0000_0000; sc = 32'h0000_0000; g = 32'h0000_FFFF;
        end
        3: begin
          ox = 32'hFFFD_0000; oz = 32'h0005_8000; sc = 32'h0000_8000; g = 32'h0000_0001;
        end
        4: begin
          ox = $urandom; oz = $urandom; sc = $urandom_range(32'h4_0000, 32'h4000);
          g = $urandom_range(65535);
        end
        default: begin
          ox = 32'h0000_0000; oz = 32'h0000_0000; sc = 32'h0001_0000; g = 32'd384;
        end
      endcase
      program_all(ox, oz, sc, g);
      repeat (16) begin
        if ($urandom_range(1)) begin
          pick_cell(gx, gz);
          query_cell(gx, gz, pick_frac(), pick_frac());
        end else begin
          query_at($urandom, $urandom);
        end
      end
      drain_results();
    end
  endtask

  task automatic test_random();
    logic [31:0] ox, oz, sc, g;
    longint gx, gz, fx, fz, tmp;
    int r, j;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 66;
        3: idle_pct = 14;
        default: idle_pct = 0;
      endcase
      r = $urandom_range(7);
      if (r < 4) begin
        ox = 32'd0; oz = 32'd0;
      end else if (r < 6) begin
        ox = $urandom_range(32'h8_0000) - 32'h4_0000;
        oz = $urandom_range(32'h8_0000) - 32'h4_0000;
      end else if (r == 6) begin
        ox = $urandom; oz = $urandom;
      end else begin
        ox = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        oz = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      r = $urandom_range(7);
      if (r < 4) sc = $urandom_range(32'h4_0000, 32'h4000);
      else if (r == 4) sc = 32'h0001_0000;
      else if (r == 5) sc = 32'h0000_0000;
      else if (r == 6) sc = 32'h00FF_FFFF;
      else sc = $urandom;
      r = $urandom_range(7);
      if (r == 0) g = 32'd0;
      else if (r == 1) g = 32'h0000_FFFF;
      else g = $urandom;
      program_all(ox, oz, sc, g);
      repeat (160) begin
        r = $urandom_range(99);
        if (r < 40) begin
          pick_cell(gx, gz);
          query_cell(gx, gz, pick_frac(), pick_frac());
        end else if (r < 55) begin
          send_word(CMD_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), $urandom, $urandom);
        end else if (r < 68) begin
          query_at($urandom, $urandom);
        end else if (r < 80) begin
          // close to the triangle diagonal
          pick_cell(gx, gz);
          fx = longint'($urandom_range(65535));
          j = $urandom_range(2);
          fz = 65536 - fx + j - 1;
          if (fz > 65535) fz = 65535;
          if (fz < 0) fz = 0;
          query_cell(gx, gz, fx, fz);
        end else if (r < 90) begin
          // rewrite a corner then query the same cell at once
          gx = longint'($urandom_range(7));
          gz = longint'($urandom_range(7));
          send_word(CMD_WRITE, 8'(gx + $urandom_range(1)), 8'(gz + $urandom_range(1)),
                    8'($urandom_range(255)), $urandom, $urandom);
          query_cell(gx, gz, pick_frac(), pick_frac());
        end else begin
          // just outside the grid on one axis
          pick_cell(gx, gz);
          j = $urandom_range(3);
          if ($urandom_range(1)) gx = LAST_X + 1 + j;
          else gx = -1 - j;
          if ($urandom_range(1)) begin
            tmp = gx; gx = gz; gz = tmp;
          end
          query_cell(gx, gz, pick_frac(), pick_frac());
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start_i <= 1'b0;
    command_i <= CMD_WRITE;
    cell_x_i <= '0;
    cell_z_i <= '0;
    height_byte_i <= '0;
    pos_x_i <= '0;
    pos_z_i <= '0;
    cfg_off_x = 32'd0;
    cfg_off_z = 32'd0;
    cfg_scale = 24'd65536;
    cfg_gain = 16'd384;
    fail_count = 0;
    idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_config_extremes();
    test_random();
    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
